[sv/rbo_pkg.sv]
// rbo_pkg: shared types, action codes and square permutation helpers
// for the rotated bitboard occupancy block. No dependencies.
`timescale 1ns / 1ps

package rbo_pkg;

  localparam int unsigned KINDS    = 4;
  localparam int unsigned SQUARES  = 64;
  localparam int unsigned LINE_LEN = 8;

  typedef enum logic [2:0] {
    ACT_ZERO  = 3'd0,
    ACT_LOAD  = 3'd1,
    ACT_SET   = 3'd2,
    ACT_CLEAR = 3'd3,
    ACT_QUERY = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    KIND_RANK = 2'd0,
    KIND_FILE = 2'd1,
    KIND_DIAG = 2'd2,
    KIND_ANTI = 2'd3
  } kind_e;

  typedef logic [KINDS-1:0][SQUARES-1:0] boards_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  square;
    logic [63:0] board;
    logic [1:0]  line_kind;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  line_bits;
    logic [63:0] rotated_word;
  } result_t;

  // bit position of square sq within board kind
  function automatic logic [5:0] sq_pos(input kind_e kind, input logic [5:0] sq);
    logic [2:0] r;
    logic [2:0] f;
    logic [5:0] p;
    r = sq[5:3];
    f = sq[2:0];
    unique case (kind)
      KIND_RANK: p = sq;
      KIND_FILE: p = {f, r};
      KIND_DIAG: p = {3'(f - r), r};
      KIND_ANTI: p = {3'(3'd7 - f - r), r};
      default:   p = sq;
    endcase
    return p;
  endfunction

  // place every square of a plain board at its position in board kind
  function automatic logic [63:0] permute(input kind_e kind, input logic [63:0] plain);
    logic [63:0] b;
    b = '0;
    for (int s = 0; s < SQUARES; s++) begin
      b[sq_pos(kind, 6'(s))] = plain[s];
    end
    return b;
  endfunction

endpackage

[sv/rbo_if.sv]
// rbo_in_if / rbo_out_if: valid-ready channels of the occupancy block.
// Depends on nothing.
`timescale 1ns / 1ps

interface rbo_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [5:0]  square;
  logic [63:0] board;
  logic [1:0]  line_kind;

  modport source (output valid, action, square, board, line_kind, input ready);
  modport sink   (input valid, action, square, board, line_kind, output ready);
endinterface

interface rbo_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  line_bits;
  logic [63:0] rotated_word;

  modport source (output valid, line_bits, rotated_word, input ready);
  modport sink   (input valid, line_bits, rotated_word, output ready);
endinterface

[sv/rbo_core.sv]
// rbo_core: next-state and result logic for one word.
// Depends on rbo_pkg.
`timescale 1ns / 1ps

module rbo_core
  import rbo_pkg::*;
(
  input  boards_t  boards_i,
  input  in_word_t word_i,
  output boards_t  boards_o,
  output result_t  result_o
);

  kind_e      kind;
  logic [5:0] qpos;
  logic [63:0] shifted;

  assign kind = kind_e'(word_i.line_kind);
  assign qpos = sq_pos(kind, word_i.square);
  assign shifted = boards_i[kind] >> {qpos[5:3], 3'b000};

  always_comb begin
    boards_o = boards_i;
    result_o.line_bits = '0;
    unique case (action_e'(word_i.action))
      ACT_ZERO: boards_o = '0;
      ACT_LOAD: begin
        for (int k = 0; k < KINDS; k++) begin
          boards_o[k] = permute(kind_e'(k), word_i.board);
        end
      end
      ACT_SET: begin
        for (int k = 0; k < KINDS; k++) begin
          boards_o[k] = boards_i[k] | (64'd1 << sq_pos(kind_e'(k), word_i.square));
        end
      end
      ACT_CLEAR: begin
        for (int k = 0; k < KINDS; k++) begin
          boards_o[k] = boards_i[k] & ~(64'd1 << sq_pos(kind_e'(k), word_i.square));
        end
      end
      ACT_QUERY: result_o.line_bits = shifted[7:0];
      default: ;  // unused codes leave the boards alone
    endcase
    result_o.rotated_word = boards_o[kind];
  end

endmodule

[sv/rotated_bitboard_occupancy.sv]
// rotated_bitboard_occupancy: top level, word register, board state, result register.
// Depends on rbo_pkg, rbo_if and rbo_core.
`timescale 1ns / 1ps

// Keeps rank, file, diagonal and anti-diagonal occupancy boards of an 8x8 grid.
// Each input word carries one action (zero, load, set, clear, query) and yields
// exactly one result word: the line byte for a query (zero otherwise) and the
// whole board picked by line_kind as it stands after the action. Throughput is
// one word per clock; a word passes the input register, then the result register.
// The rate comes from the board read-modify-write, which is combinational
// between those registers, so the next word always sees the boards left by
// the one before. Reset clears all four boards at once; there is no clearing
// pass. A stalled result holds the pipe, and input ready drops only while the
// result register is full and not being taken.

module rotated_bitboard_occupancy
  import rbo_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  rbo_in_if.sink       in_i,
  rbo_out_if.source    out_o
);

  // input stage
  logic     s1_valid_q, s1_valid_d;
  in_word_t s1_word_q;
  // result stage
  logic     out_valid_q, out_valid_d;
  result_t  out_res_q;
  // board state
  boards_t  boards_q, boards_d;

  boards_t  core_boards;
  result_t  core_res;
  logic     in_fire;
  logic     s1_adv;

  rbo_core u_core (
    .boards_i (boards_q),
    .word_i   (s1_word_q),
    .boards_o (core_boards),
    .result_o (core_res)
  );

  // stage 1 may move on whenever the result slot is free or emptying
  assign s1_adv  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !out_o.ready);
  assign boards_d    = s1_adv ? core_boards : boards_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      boards_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      boards_q    <= boards_d;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q.action    <= in_i.action;
      s1_word_q.square    <= in_i.square;
      s1_word_q.board     <= in_i.board;
      s1_word_q.line_kind <= in_i.line_kind;
    end
    if (s1_adv) begin
      out_res_q <= core_res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.line_bits    = out_res_q.line_bits;
  assign out_o.rotated_word = out_res_q.rotated_word;

endmodule

[sv/rbo_checker.sv]
// rbo_checker: port-level checks for rotated_bitboard_occupancy, with its bind.
// Depends on rotated_bitboard_occupancy and rbo_if.
`timescale 1ns / 1ps

module rbo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  line_bits_i,
  input logic [63:0] rotated_word_i
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(line_bits_i) && $stable(rotated_word_i))
    else $error("result word changed while stalled");

  // back-pressure only comes from a full, stalled result register
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output stall");

  // a fresh result follows an accepted word through the input and result registers
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_fire, 2))
    else $error("result word without matching input");

endmodule

bind rotated_bitboard_occupancy rbo_checker u_rbo_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .line_bits_i    (out_o.line_bits),
  .rotated_word_i (out_o.rotated_word)
);

[test/tb.sv]
// tb: self-checking bench for rotated_bitboard_occupancy, directed table then random words.
// Depends on rbo_pkg, rbo_if (rbo_in_if, rbo_out_if) and the block under test.
`timescale 1ns / 1ps

module tb;
  import rbo_pkg::*;

  // action codes the block leaves unnamed; they must leave the boards alone
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_MID = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam int unsigned RAND_WORDS = 1450;
  localparam int unsigned HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int unsigned HOLD_AT = 500;       // random word at which it starts
  localparam int unsigned DRAIN_AT = 1000;     // sender waits for empty pipe here
  localparam int unsigned IDLE_LIMIT = 3000;   // watchdog: cycles with no word moving
  localparam int unsigned TAIL_CYCLES = 4;     // extra wait after the drain, with margin

  localparam logic [63:0] ALL_ONES = '1;

  // one row of the directed table; typed rows carry their result by hand
  typedef struct {
    in_word_t w;
    bit       typed;
    result_t  r;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  rbo_in_if  in_bus ();
  rbo_out_if out_bus ();

  rotated_bitboard_occupancy dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // predictor state: the four occupancy boards, indexed by kind
  logic [63:0] occ_q [KINDS];

  result_t  pending_q[$];   // results still owed by the block, oldest first
  dir_row_t dir_q[$];

  int unsigned err_cnt;
  int unsigned n_words;
  int unsigned n_results;
  int unsigned n_queries;
  int unsigned idle_cnt;
  bit          burst;       // no idling on either side while set
  bit          hold_req;    // sender asks the receiver for a long hold-off

  // Where square sq lands in board k: upper three bits pick the line (byte),
  // lower three the place along it. Rank: line is the rank. File: line is the
  // file. The two rotations wrap the file against the rank modulo 8, which
  // folds each diagonal into one byte with the rank as its index.
  function automatic logic [5:0] bit_at(input kind_e k, input logic [5:0] sq);
    logic [2:0] rk;
    logic [2:0] fl;
    logic [2:0] ln;
    logic [2:0] ix;
    rk = sq[5:3];
    fl = sq[2:0];
    ln = rk;
    ix = fl;
    case (k)
      KIND_RANK: begin
        ln = rk;
        ix = fl;
      end
      KIND_FILE: begin
        ln = fl;
        ix = rk;
      end
      KIND_DIAG: begin
        ln = fl - rk;
        ix = rk;
      end
      KIND_ANTI: begin
        ln = 3'd7 - fl - rk;
        ix = rk;
      end
      default: begin
        ln = rk;
        ix = fl;
      end
    endcase
    bit_at = {ln, ix};
  endfunction

  // Apply one word to the predicted boards and work out its result.
  task automatic step_boards(input in_word_t w, output result_t r);
    kind_e      k;
    logic [5:0] p;
    k = kind_e'(w.line_kind);
    r.line_bits = '0;
    case (w.action)
      ACT_ZERO: begin
        for (int i = 0; i < KINDS; i++) occ_q[i] = '0;
      end
      ACT_LOAD: begin
        for (int i = 0; i < KINDS; i++) begin
          occ_q[i] = '0;
          for (int s = 0; s < SQUARES; s++)
            if (w.board[s]) occ_q[i][bit_at(kind_e'(i), 6'(s))] = 1'b1;
        end
      end
      ACT_SET: begin
        for (int i = 0; i < KINDS; i++) occ_q[i][bit_at(kind_e'(i), w.square)] = 1'b1;
      end
      ACT_CLEAR: begin
        for (int i = 0; i < KINDS; i++) occ_q[i][bit_at(kind_e'(i), w.square)] = 1'b0;
      end
      ACT_QUERY: begin
        p = bit_at(k, w.square);
        r.line_bits = 8'(occ_q[k] >> {p[5:3], 3'b000});
        n_queries++;
      end
      default: ;  // spare codes: boards untouched
    endcase
    r.rotated_word = occ_q[k];
  endtask

  function automatic dir_row_t mk_row(input logic [2:0] act, input logic [5:0] sq,
                                      input logic [63:0] brd, input kind_e k,
                                      input bit typed, input logic [7:0] line,
                                      input logic [63:0] word);
    dir_row_t d;
    d.w.action = act;
    d.w.square = sq;
    d.w.board = brd;
    d.w.line_kind = k;
    d.typed = typed;
    d.r.line_bits = line;
    d.r.rotated_word = word;
    return d;
  endfunction

  // Random word: mostly set, clear and query so the boards fill and empty,
  // with the odd load or wipe, and a few spare codes as noise.
  function automatic in_word_t rand_word();
    in_word_t   w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) w.action = ACT_SET;
    else if (pick < 50) w.action = ACT_CLEAR;
    else if (pick < 85) w.action = ACT_QUERY;
    else if (pick < 92) w.action = ACT_LOAD;
    else if (pick < 95) w.action = ACT_ZERO;
    else w.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    w.square = 6'($urandom_range(0, 63));
    w.line_kind = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 9);
    if (pick == 0) w.board = ALL_ONES;
    else if (pick == 1) w.board = '0;
    else w.board = {32'($urandom), 32'($urandom)};
    return w;
  endfunction

  function automatic int unsigned draw_gap();
    return burst ? 0 : $urandom_range(0, 17);
  endfunction

  // Offer one word after an idle gap and hold it until taken. Valid is only
  // lowered when a gap follows, so back-to-back words keep it high.
  task automatic offer_word(input in_word_t w, input bit typed, input result_t typed_r);
    result_t     pr;
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.action <= w.action;
    in_bus.square <= w.square;
    in_bus.board <= w.board;
    in_bus.line_kind <= w.line_kind;
    do @(posedge clk_i); while (!in_bus.ready);
    step_boards(w, pr);
    pending_q.push_back(typed ? typed_r : pr);
    n_words++;
  endtask

  // clock: 8 ns period
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: a fresh stall before each result, or the long hold-off on request.
  initial begin
    int unsigned w8;
    out_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        w8 = draw_gap();
        if (w8 > 0) begin
          out_bus.ready <= 1'b0;
          repeat (w8) @(posedge clk_i);
        end
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_bus.valid && out_bus.ready));
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: line_bits %h rotated_word %h",
               out_bus.line_bits, out_bus.rotated_word);
        err_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (out_bus.line_bits !== e.line_bits) begin
          $error("line_bits: expected %h, got %h", e.line_bits, out_bus.line_bits);
          err_cnt++;
        end
        if (out_bus.rotated_word !== e.rotated_word) begin
          $error("rotated_word: expected %h, got %h", e.rotated_word, out_bus.rotated_word);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: too long without a word moving on either channel ends the run.
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random words with pressure, drain.
  initial begin
    in_word_t w;
    result_t  none;
    err_cnt = 0;
    n_words = 0;
    n_results = 0;
    n_queries = 0;
    idle_cnt = 0;
    burst = 1'b0;
    hold_req = 1'b0;
    none = '0;
    for (int i = 0; i < KINDS; i++) occ_q[i] = '0;

    rst_ni <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.action <= ACT_ZERO;
    in_bus.square <= '0;
    in_bus.board <= '0;
    in_bus.line_kind <= KIND_RANK;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Typed rows: reads of empty and full boards, the all-ones load
    // (every permutation of all ones is all ones), corner squares on the
    // rank board, repeat set and clear, and wipes. The rest go to the predictor.
    dir_q.push_back(mk_row(ACT_QUERY, 6'd0, '0, KIND_RANK, 1, 8'h00, '0));
    dir_q.push_back(mk_row(ACT_QUERY, 6'd63, ALL_ONES, KIND_ANTI, 1, 8'h00, '0));
    dir_q.push_back(mk_row(ACT_LOAD, 6'd0, ALL_ONES, KIND_RANK, 1, 8'h00, ALL_ONES));
    dir_q.push_back(mk_row(ACT_QUERY, 6'd27, '0, KIND_DIAG, 1, 8'hFF, ALL_ONES));
    dir_q.push_back(mk_row(ACT_QUERY, 6'd63, '0, KIND_FILE, 1, 8'hFF, ALL_ONES));
    dir_q.push_back(mk_row(ACT_CLEAR, 6'd0, '0, KIND_RANK, 1, 8'h00,
                           64'hFFFF_FFFF_FFFF_FFFE));
    dir_q.push_back(mk_row(ACT_CLEAR, 6'd0, '0, KIND_RANK, 1, 8'h00,
                           64'hFFFF_FFFF_FFFF_FFFE));
    dir_q.push_back(mk_row(ACT_CLEAR, 6'd63, '0, KIND_FILE, 0, 8'h00, '0));
    dir_q.push_back(mk_row(ACT_QUERY, 6'd0, '0, KIND_FILE, 0, 8'h00, '0));
    dir_q.push_back(mk_row(ACT_ZERO, 6'd17, ALL_ONES, KIND_ANTI, 1, 8'h00, '0));
    dir_q.push_back(mk_row(ACT_CLEAR, 6'd5, '0, KIND_DIAG, 1, 8'h00, '0));
    dir_q.push_back(mk_row(ACT_SET, 6'd0, '0, KIND_RANK, 1, 8'h00, 64'h1));
    dir_q.push_back(mk_row(ACT_SET, 6'd0, '0, KIND_RANK, 1, 8'h00, 64'h1));
    dir_q.push_back(mk_row(ACT_SET, 6'd63, '0, KIND_RANK, 1, 8'h00,
                           64'h8000_0000_0000_0001));
    dir_q.push_back(mk_row(ACT_SET, 6'd63, '0, KIND_ANTI, 0, 8'h00, '0));
    dir_q.push_back(mk_row(ACT_QUERY, 6'd63, '0, KIND_RANK, 1, 8'h80,
                           64'h8000_0000_0000_0001));
    dir_q.push_back(mk_row(ACT_QUERY, 6'd7, '0, KIND_DIAG, 0, 8'h00, '0));
    dir_q.push_back(mk_row(ACT_SPARE_LO, 6'd63, ALL_ONES, KIND_FILE, 0, 8'h00, '0));
    dir_q.push_back(mk_row(ACT_SPARE_MID, 6'd9, ALL_ONES, KIND_DIAG, 0, 8'h00, '0));
    dir_q.push_back(mk_row(ACT_SPARE_HI, 6'd54, ALL_ONES, KIND_ANTI, 0, 8'h00, '0));
    dir_q.push_back(mk_row(ACT_LOAD, 6'd0, 64'hAAAA_AAAA_AAAA_AAAA, KIND_FILE, 0, 8'h00, '0));
    dir_q.push_back(mk_row(ACT_LOAD, 6'd0, 64'h5555_5555_5555_5555, KIND_DIAG, 0, 8'h00, '0));
    dir_q.push_back(mk_row(ACT_QUERY, 6'd36, '0, KIND_ANTI, 0, 8'h00, '0));
    dir_q.push_back(mk_row(ACT_LOAD, 6'd0, '0, KIND_RANK, 1, 8'h00, '0));
    dir_q.push_back(mk_row(ACT_ZERO, 6'd0, '0, KIND_DIAG, 1, 8'h00, '0));

    foreach (dir_q[i]) offer_word(dir_q[i].w, dir_q[i].typed, dir_q[i].r);

    // Random part. Bursts with no idling span 64 words out of every 192; the
    // hold-off window sends gap-free so the pipe fills and input ready drops.
    for (int unsigned i = 0; i < RAND_WORDS; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == DRAIN_AT) begin
        // pause until the block has handed back everything it owes
        in_bus.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
      end
      if (i >= HOLD_AT && i < HOLD_AT + 60) burst = 1'b1;
      else burst = ((i / 64) % 3) == 1;
      w = rand_word();
      offer_word(w, 1'b0, none);
    end
    in_bus.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d words (%0d queries) and %0d results, incl. all actions,",
             n_words, n_queries, n_results);
    $display("spare codes, all four line kinds, bursts, long output stall and a drain");
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
